### hw/rtl/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

  // field widths
  localparam int VAL_W  = 24;
  localparam int GAIN_W = 16;
  localparam int SIZE_W = 11;
  localparam int CFG_W  = 16;

  // configuration register indexes
  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd13107;
  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd64;

  // saturation bounds of signed Q4.20
  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7fffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    is_padding;
  } dss_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic                    frame_end;
  } dss_out_t;

endpackage

### hw/rtl/diffusion_stencil_step.sv
`timescale 1ns / 1ps

// the input word of the row below runs through the pipeline registers to yield a result word
// throughput: one input word per cycle while in_stall_o is low; the center store takes two
// reads and a write per word taken, the previous store a read and a write
// words of the first grid row give no result, all others give exactly one
// reset clears the counters and the pipeline and loads the register defaults;
// the row stores are not cleared and are written before their contents are used
module diffusion_stencil_step import dss_pkg::*; #(
  parameter int MAX_GRID = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dss_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dss_out_t         out_word_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW   = $clog2(MAX_GRID);
  localparam int GW   = $clog2(MAX_GRID + 1);
  localparam int NW   = (GW > SIZE_W) ? GW : SIZE_W;
  localparam int LW   = VAL_W + 3;
  localparam int PW   = LW + GAIN_W + 1;
  localparam int DW   = PW - 16;
  localparam int SW   = DW + 1;

  // configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      size_q <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_SIZE: size_q <= cfg_data_i[SIZE_W-1:0];
        default:  gain_q <= gain_q;
      endcase
    end
  end

  // effective grid size clamped to [2, MAX_GRID]
  logic [NW-1:0] size_ext;
  logic [NW-1:0] n_size;

  always_comb begin
    size_ext = NW'(size_q);
    if (size_ext < NW'(2)) begin
      n_size = NW'(2);
    end else if (size_ext > NW'(MAX_GRID)) begin
      n_size = NW'(MAX_GRID);
    end else begin
      n_size = size_ext;
    end
  end

  // pipeline handshake
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic prod1_q;
  logic en_o, en3, en2, en1;
  logic accept, s1_go;

  assign en_o   = !out_valid_q || !out_stall_i;
  assign en3    = !v3_q || en_o;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || !prod1_q || en2;
  assign accept = in_valid_i && en1;
  assign s1_go  = v1_q && en1;

  assign in_stall_o = !en1;

  // frame position counters
  logic [CW-1:0] col_q;
  logic [NW-1:0] row_q;
  logic          pad_row, last_col;

  assign pad_row  = row_q >= n_size;
  assign last_col = NW'(col_q) >= (n_size - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= pad_row ? '0 : row_q + NW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  logic signed [VAL_W-1:0] down_in;
  assign down_in = pad_row ? '0 : in_word_i.cell_value;

  // center row store: read center and right neighbour, replace center with the new row
  logic [VAL_W-1:0] center_mem [MAX_GRID];
  logic [VAL_W-1:0] rd_center_q, rd_right_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_center_q     <= center_mem[col_q];
      rd_right_q      <= center_mem[col_q + CW'(1)];
      center_mem[col_q] <= down_in;
    end
  end

  // previous row store: read on accept, old center written back from rd_center_q when stage 1 advances
  logic [VAL_W-1:0] prev_mem [MAX_GRID];
  logic [VAL_W-1:0] rd_prev_q;
  logic [CW-1:0]    col1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_prev_q <= prev_mem[col_q];
    end
    if (s1_go) begin
      prev_mem[col1_q] <= rd_center_q;
    end
  end

  // stage 1 side info
  logic signed [VAL_W-1:0] down1_q;
  logic                    up1_q, left1_q, last1_q, fend1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      prod1_q <= 1'b0;
    end else if (en1) begin
      v1_q    <= accept;
      prod1_q <= row_q != '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col1_q  <= col_q;
      down1_q <= down_in;
      up1_q   <= row_q >= NW'(2);
      left1_q <= col_q != '0;
      last1_q <= last_col;
      fend1_q <= pad_row && last_col;
    end
  end

  // old center of the column to the left
  logic signed [VAL_W-1:0] left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (s1_go) begin
      left_q <= rd_center_q;
    end
  end

  // stage 1: laplacian sum
  logic signed [LW-1:0] lap;

  always_comb begin
    lap = LW'($signed(down1_q))
        + (up1_q   ? LW'($signed(rd_prev_q))  : LW'(0))
        + (left1_q ? LW'(left_q)              : LW'(0))
        + (last1_q ? LW'(0)                   : LW'($signed(rd_right_q)))
        - (LW'($signed(rd_center_q)) <<< 2);
  end

  logic signed [LW-1:0]    lap2_q;
  logic signed [VAL_W-1:0] center2_q, center3_q;
  logic                    fend2_q, fend3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && prod1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      lap2_q    <= lap;
      center2_q <= $signed(rd_center_q);
      fend2_q   <= fend1_q;
    end
  end

  // stage 2: gain multiply
  logic signed [PW-1:0] prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      prod3_q   <= PW'(lap2_q * $signed({1'b0, gain_q}));
      center3_q <= center2_q;
      fend3_q   <= fend2_q;
    end
  end

  // stage 3: round, add and saturate
  logic signed [PW-1:0]    rounded;
  logic signed [DW-1:0]    delta;
  logic signed [SW-1:0]    sum;
  logic signed [VAL_W-1:0] sat;

  always_comb begin
    rounded = prod3_q + PW'(32768);
    delta   = rounded[PW-1:16];
    sum     = SW'(center3_q) + SW'(delta);
    if (sum > SW'(VAL_MAX)) begin
      sat = VAL_MAX;
    end else if (sum < SW'(VAL_MIN)) begin
      sat = VAL_MIN;
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  // output register
  dss_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v3_q) begin
      out_q.new_value <= sat;
      out_q.frame_end <= fend3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
